>>> rtl/rac_pkg.sv
// Shared types, codes and widths for the resource admission controller.
// Used by every module of the block; depends on nothing.
package rac_pkg;

   localparam int ID_W     = 8;
   localparam int MB_W     = 20;
   localparam int GPU_W    = 3;
   localparam int PRIO_W   = 8;
   localparam int STAMP_W  = 32;
   localparam int GFREE_W  = 21;
   localparam int RETRY_W  = 16;
   localparam int LIMIT_W  = 5;
   localparam int MODELS_W = 5;
   localparam int GPU_COUNT = 8;
   localparam int DEF_TABLE_DEPTH = 16;
   localparam int MAX_VICTIMS = 16;
   localparam int VCNT_W   = $clog2(MAX_VICTIMS + 1);
   localparam int RECL_W   = MB_W + VCNT_W;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd4;
   localparam logic [RETRY_W-1:0] RETRY_RESET = 16'd1000;

   typedef enum logic [1:0] {
      OP_CLAIM   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_BUSY    = 2'd2,
      OP_IDLE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      REG_MODEL_LIMIT = 2'd0,
      REG_RETRY_DELAY = 2'd1,
      REG_RAM_RESERVE = 2'd2,
      REG_VRAM_RESERVE = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      DEC_ALLOW     = 3'd0,
      DEC_DENY      = 3'd1,
      DEC_DEFER     = 3'd2,
      DEC_THROTTLE  = 3'd3,
      DEC_EVICT     = 3'd4,
      DEC_DONE      = 3'd5,
      DEC_NOT_FOUND = 3'd6
   } decision_type;

   typedef enum logic [2:0] {
      CAUSE_NONE      = 3'd0,
      CAUSE_DUPLICATE = 3'd1,
      CAUSE_MODELS    = 3'd2,
      CAUSE_RAM       = 3'd3,
      CAUSE_VRAM      = 3'd4,
      CAUSE_PRESSURE  = 3'd5,
      CAUSE_FULL      = 3'd6
   } cause_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic               model;
      logic [MB_W-1:0]    ram_mb;
      logic [MB_W-1:0]    vram_mb;
      logic [GPU_W-1:0]   gpu;
      logic [PRIO_W-1:0]  priority_lvl;
      logic               busy;
      logic [STAMP_W-1:0] stamp;
   } slot_entry_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] model_limit;
      logic [RETRY_W-1:0] retry_delay_ms;
      logic [MB_W-1:0]    ram_keep_mb;
      logic [MB_W-1:0]    vram_keep_mb;
   } cfg_regs_type;

   typedef struct packed {
      logic                      pressure_critical;
      logic signed [GFREE_W-1:0] gpu_free_mb;
      logic [MB_W-1:0]           ram_free_mb;
      logic                      allow_defer;
      logic                      allow_evict;
      logic [PRIO_W-1:0]         claim_priority;
      logic [GPU_W-1:0]          gpu_index;
      logic [MB_W-1:0]           vram_need_mb;
      logic [MB_W-1:0]           ram_need_mb;
      logic                      is_model;
      logic [ID_W-1:0]           client_id;
   } req_item_type;

   typedef struct packed {
      decision_type        decision;
      cause_type           cause;
      logic [RETRY_W-1:0]  retry_ms;
      logic                victim_valid;
      logic [ID_W-1:0]     victim_id;
      logic                last_result;
      logic [MODELS_W-1:0] models_held;
   } result_type;

   function automatic result_type make_result(decision_type dec, cause_type cs,
                                              logic [RETRY_W-1:0] retry, logic vv,
                                              logic [ID_W-1:0] vid, logic last,
                                              logic [MODELS_W-1:0] models);
      result_type r;
      r.decision     = dec;
      r.cause        = cs;
      r.retry_ms     = retry;
      r.victim_valid = vv;
      r.victim_id    = vid;
      r.last_result  = last;
      r.models_held  = models;
      return r;
   endfunction

endpackage

>>> rtl/rac_csr.sv
// APB-style register file for the admission controller settings.
// Depends on rac_pkg for the register codes and the settings struct.
module rac_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [rac_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rac_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rac_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output rac_pkg::cfg_regs_type          cfg
);
   import rac_pkg::*;

   cfg_regs_type  cfg_ff;
   cfg_regs_type  cfg_in;
   reg_index_type reg_sel;
   logic          wr_en;

   assign reg_sel    = reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_MODEL_LIMIT:  cfg_in.model_limit    = csr_pwdata[LIMIT_W-1:0];
            REG_RETRY_DELAY:  cfg_in.retry_delay_ms = csr_pwdata[RETRY_W-1:0];
            REG_RAM_RESERVE:  cfg_in.ram_keep_mb    = csr_pwdata[MB_W-1:0];
            REG_VRAM_RESERVE: cfg_in.vram_keep_mb   = csr_pwdata[MB_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_MODEL_LIMIT:  csr_prdata = CSR_DATA_W'(cfg_ff.model_limit);
         REG_RETRY_DELAY:  csr_prdata = CSR_DATA_W'(cfg_ff.retry_delay_ms);
         REG_RAM_RESERVE:  csr_prdata = CSR_DATA_W'(cfg_ff.ram_keep_mb);
         REG_VRAM_RESERVE: csr_prdata = CSR_DATA_W'(cfg_ff.vram_keep_mb);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.model_limit    <= LIMIT_RESET;
         cfg_ff.retry_delay_ms <= RETRY_RESET;
         cfg_ff.ram_keep_mb    <= '0;
         cfg_ff.vram_keep_mb   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/rac_table.sv
// Holder table: one entry per slot with a valid bit per slot, one read index.
// Depends on rac_pkg for the slot entry struct.
module rac_table #(
   parameter int TABLE_DEPTH = rac_pkg::DEF_TABLE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [$clog2(TABLE_DEPTH)-1:0] rd_idx,
   output logic                           rd_valid,
   output rac_pkg::slot_entry_type        rd_entry,
   input  logic                           wr_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0] wr_idx,
   input  rac_pkg::slot_entry_type        wr_entry,
   input  logic                           clr_en,
   input  logic                           busy_en,
   input  logic                           busy_val,
   input  logic [$clog2(TABLE_DEPTH)-1:0] mod_idx
);
   import rac_pkg::*;

   slot_entry_type         slot_ff [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;

   assign rd_valid = valid_ff[rd_idx];
   assign rd_entry = slot_ff[rd_idx];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_idx] <= wr_entry;
      end
      if (busy_en) begin
         slot_ff[mod_idx].busy <= busy_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
         if (clr_en) begin
            valid_ff[mod_idx] <= 1'b0;
         end
      end
   end

endmodule

>>> rtl/resource_admission_controller.sv
// Resource admission controller: holder table with claim, release, busy and
// idle operations, judged by one sequencer sweeping the table a slot a cycle.
// Items arrive on req_* (tuser: operation; tdata: the claim fields). Results
// leave on rsp_* (tdata: decision, cause, retry, victim id, models held;
// tuser: victim_valid; tlast: last result of the item). Settings are written
// through the csr_* port; the user must write them only while the block is
// idle, as the block itself does not enforce it. Every item first takes one
// sweep of the table to find the id, a free slot, the RAM held and the VRAM
// held on its GPU, then a decision step and a push step that loads the output
// register; the sequencer then returns to idle and takes the next item, so no
// item is accepted until the last one's result is loaded. A claim that lists
// victims adds a sweep, a pick and a push per victim, up to sixteen, and one
// more sweep and pick when the idle candidates run out first. All sweeps share
// the one table read port. req_tready is high only while the sequencer is idle.
// One output register holds a result; when rsp_tready is low the sequencer
// waits on it and no further result is lost or repeated.
// Reset empties the table, zeroes the admission stamp counter and restores
// the default settings; no clearing pass is needed.
module resource_admission_controller #(
   parameter int TABLE_DEPTH = rac_pkg::DEF_TABLE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // id, is_model, ram_need, vram_need, gpu, priority, allow_evict,
   // allow_defer, ram_free, gpu_free, pressure_critical
   input  logic [103:0]                   req_tdata,
   // operation
   input  logic [1:0]                     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // decision, cause, retry_ms, victim_id, models_held
   output logic [39:0]                    rsp_tdata,
   // victim_valid
   output logic                           rsp_tuser,
   output logic                           rsp_tlast,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [rac_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rac_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rac_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import rac_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int SUM_W = MB_W + IDX_W + 1;
   localparam int CMP_W = SUM_W + 2;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_SCAN   = 7'b0000010,
      S_DECIDE = 7'b0000100,
      S_ROUND  = 7'b0001000,
      S_PICK   = 7'b0010000,
      S_PUSH   = 7'b0100000,
      S_FINAL  = 7'b1000000
   } state_type;

   cfg_regs_type   cfg;
   logic           rd_valid;
   slot_entry_type rd_entry;
   logic [IDX_W-1:0] rd_idx;
   logic           wr_en, clr_en, busy_en, busy_val;
   slot_entry_type wr_entry;

   state_type      state_ff, state_in, ret_ff, ret_in;
   req_item_type   item_ff, item_in;
   op_type         op_ff, op_in;
   logic [IDX_W-1:0] idx_ff, idx_in, match_idx_ff, match_idx_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in, best_idx_ff, best_idx_in;
   logic           match_ff, match_in, free_ff, free_in, found_ff, found_in;
   logic [SUM_W-1:0] ram_sum_ff, ram_sum_in, vram_sum_ff, vram_sum_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [STAMP_W-1:0] admit_ff, admit_in, best_age_ff, best_age_in;
   cause_type      cause_ff, cause_in;
   logic           bygpu_ff, bygpu_in, have_pend_ff, have_pend_in;
   logic [MB_W-1:0] need_ff, need_in, best_amt_ff, best_amt_in;
   logic [TABLE_DEPTH-1:0] taken_ff, taken_in;
   logic [VCNT_W-1:0] nvic_ff, nvic_in;
   logic [RECL_W-1:0] recl_ff, recl_in;
   logic [ID_W-1:0] pend_id_ff, pend_id_in, best_id_ff, best_id_in;
   logic [PRIO_W-1:0] best_prio_ff, best_prio_in;
   result_type     res_ff, res_in, rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;

   logic [STAMP_W-1:0] age;
   logic               eligible, better, push_go, stop;
   logic [MODELS_W-1:0] models_now;
   logic signed [CMP_W-1:0] ram_avail, vram_avail;
   logic               ram_bad, vram_bad, gpu_ok;
   logic [RECL_W-1:0]  recl_next;
   logic [VCNT_W-1:0]  nvic_next;

   rac_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rac_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (rd_idx),
      .rd_valid (rd_valid),
      .rd_entry (rd_entry),
      .wr_en    (wr_en),
      .wr_idx   (free_idx_ff),
      .wr_entry (wr_entry),
      .clr_en   (clr_en),
      .busy_en  (busy_en),
      .busy_val (busy_val),
      .mod_idx  (match_idx_ff)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_ff.models_held, rsp_ff.victim_id, rsp_ff.retry_ms,
                        rsp_ff.cause, rsp_ff.decision};
   assign rsp_tuser  = rsp_ff.victim_valid;
   assign rsp_tlast  = rsp_ff.last_result;

   assign rd_idx     = (state_ff == S_DECIDE) ? match_idx_ff : idx_ff;
   assign models_now = MODELS_W'(cnt_ff);
   assign age        = admit_ff - rd_entry.stamp;
   assign eligible   = rd_valid && !rd_entry.busy && !taken_ff[idx_ff] &&
                       (!bygpu_ff || rd_entry.gpu == item_ff.gpu_index);
   assign better     = !found_ff || (rd_entry.priority_lvl < best_prio_ff) ||
                       ((rd_entry.priority_lvl == best_prio_ff) && (age > best_age_ff));
   assign push_go    = !rsp_valid_ff || rsp_tready;

   assign ram_avail  = CMP_W'(item_ff.ram_free_mb) - CMP_W'(ram_sum_ff)
                       - CMP_W'(cfg.ram_keep_mb);
   assign ram_bad    = (item_ff.ram_need_mb != '0) &&
                       (ram_avail < $signed(CMP_W'(item_ff.ram_need_mb)));
   assign gpu_ok     = !item_ff.gpu_free_mb[GFREE_W-1] &&
                       (32'(item_ff.gpu_index) < GPU_COUNT);
   assign vram_avail = CMP_W'(item_ff.gpu_free_mb) - CMP_W'(vram_sum_ff)
                       - CMP_W'(cfg.vram_keep_mb);
   assign vram_bad   = (item_ff.vram_need_mb != '0) &&
                       (!gpu_ok || (vram_avail < $signed(CMP_W'(item_ff.vram_need_mb))));

   assign recl_next  = recl_ff + RECL_W'(best_amt_ff);
   assign nvic_next  = nvic_ff + 1'b1;
   assign stop       = (32'(nvic_next) == MAX_VICTIMS) ||
                       ((need_ff != '0) && (recl_next >= RECL_W'(need_ff)));

   always_comb begin
      wr_entry.id           = item_ff.client_id;
      wr_entry.model        = item_ff.is_model;
      wr_entry.ram_mb       = item_ff.ram_need_mb;
      wr_entry.vram_mb      = item_ff.vram_need_mb;
      wr_entry.gpu          = item_ff.gpu_index;
      wr_entry.priority_lvl = item_ff.claim_priority;
      wr_entry.busy         = 1'b0;
      wr_entry.stamp        = admit_ff;
   end

   always_comb begin
      state_in = state_ff;   ret_in = ret_ff;       item_in = item_ff;
      op_in = op_ff;         idx_in = idx_ff;       match_idx_in = match_idx_ff;
      free_idx_in = free_idx_ff; best_idx_in = best_idx_ff;
      match_in = match_ff;   free_in = free_ff;     found_in = found_ff;
      ram_sum_in = ram_sum_ff; vram_sum_in = vram_sum_ff;
      cnt_in = cnt_ff;       admit_in = admit_ff;   best_age_in = best_age_ff;
      cause_in = cause_ff;   bygpu_in = bygpu_ff;   have_pend_in = have_pend_ff;
      need_in = need_ff;     best_amt_in = best_amt_ff; taken_in = taken_ff;
      nvic_in = nvic_ff;     recl_in = recl_ff;     pend_id_in = pend_id_ff;
      best_id_in = best_id_ff; best_prio_in = best_prio_ff;
      res_in = res_ff;       rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      wr_en = 1'b0;  clr_en = 1'b0;  busy_en = 1'b0;  busy_val = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               item_in     = req_item_type'(req_tdata);
               op_in       = op_type'(req_tuser);
               idx_in      = '0;
               match_in    = 1'b0;
               free_in     = 1'b0;
               ram_sum_in  = '0;
               vram_sum_in = '0;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            if (rd_valid) begin
               ram_sum_in = ram_sum_ff + SUM_W'(rd_entry.ram_mb);
               if (rd_entry.gpu == item_ff.gpu_index) begin
                  vram_sum_in = vram_sum_ff + SUM_W'(rd_entry.vram_mb);
               end
               if (rd_entry.id == item_ff.client_id && !match_ff) begin
                  match_in     = 1'b1;
                  match_idx_in = idx_ff;
               end
            end else if (!free_ff) begin
               free_in     = 1'b1;
               free_idx_in = idx_ff;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_PUSH;
            ret_in   = S_IDLE;
            if (op_ff != OP_CLAIM) begin
               if (!match_ff) begin
                  res_in = make_result(DEC_NOT_FOUND, CAUSE_NONE, '0, 1'b0, '0, 1'b1,
                                       models_now);
               end else begin
                  if (op_ff == OP_RELEASE) begin
                     clr_en = 1'b1;
                     cnt_in = cnt_ff - CNT_W'(rd_entry.model);
                  end else begin
                     busy_en  = 1'b1;
                     busy_val = (op_ff == OP_BUSY);
                  end
                  res_in = make_result(DEC_DONE, CAUSE_NONE, '0, 1'b0, '0, 1'b1,
                                       MODELS_W'(cnt_in));
               end
            end else if (match_ff) begin
               res_in = make_result(DEC_DENY, CAUSE_DUPLICATE, '0, 1'b0, '0, 1'b1,
                                    models_now);
            end else if ((item_ff.is_model && (32'(cnt_ff) >= 32'(cfg.model_limit)))
                         || ram_bad || vram_bad) begin
               if (item_ff.is_model && (32'(cnt_ff) >= 32'(cfg.model_limit))) begin
                  cause_in = CAUSE_MODELS;
                  bygpu_in = 1'b1;
                  need_in  = item_ff.vram_need_mb;
               end else if (ram_bad) begin
                  cause_in = CAUSE_RAM;
                  bygpu_in = 1'b0;
                  need_in  = '0;
               end else begin
                  cause_in = CAUSE_VRAM;
                  bygpu_in = 1'b1;
                  need_in  = item_ff.vram_need_mb;
               end
               if (item_ff.allow_evict) begin
                  taken_in     = '0;
                  nvic_in      = '0;
                  recl_in      = '0;
                  have_pend_in = 1'b0;
                  idx_in       = '0;
                  found_in     = 1'b0;
                  state_in     = S_ROUND;
               end else if (item_ff.allow_defer) begin
                  res_in = make_result(DEC_DEFER, cause_in, cfg.retry_delay_ms, 1'b0, '0,
                                       1'b1, models_now);
               end else begin
                  res_in = make_result(DEC_DENY, cause_in, '0, 1'b0, '0, 1'b1, models_now);
               end
            end else if (item_ff.pressure_critical) begin
               if (item_ff.allow_defer) begin
                  res_in = make_result(DEC_DEFER, CAUSE_PRESSURE, cfg.retry_delay_ms, 1'b0,
                                       '0, 1'b1, models_now);
               end else begin
                  res_in = make_result(DEC_THROTTLE, CAUSE_PRESSURE, '0, 1'b0, '0, 1'b1,
                                       models_now);
               end
            end else if (!free_ff) begin
               res_in = make_result(DEC_DENY, CAUSE_FULL, '0, 1'b0, '0, 1'b1, models_now);
            end else begin
               wr_en    = 1'b1;
               admit_in = admit_ff + 1'b1;
               cnt_in   = cnt_ff + CNT_W'(item_ff.is_model);
               res_in   = make_result(DEC_ALLOW, CAUSE_NONE, '0, 1'b0, '0, 1'b1,
                                      MODELS_W'(cnt_in));
            end
         end
         S_ROUND: begin
            if (eligible && better) begin
               found_in     = 1'b1;
               best_idx_in  = idx_ff;
               best_prio_in = rd_entry.priority_lvl;
               best_age_in  = age;
               best_id_in   = rd_entry.id;
               best_amt_in  = bygpu_ff ? rd_entry.vram_mb : rd_entry.ram_mb;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            if (found_ff) begin
               taken_in[best_idx_ff] = 1'b1;
               recl_in      = recl_next;
               nvic_in      = nvic_next;
               pend_id_in   = best_id_ff;
               have_pend_in = 1'b1;
               if (have_pend_ff) begin
                  res_in   = make_result(DEC_EVICT, cause_ff, '0, 1'b1, pend_id_ff, 1'b0,
                                         models_now);
                  ret_in   = stop ? S_FINAL : S_ROUND;
                  state_in = S_PUSH;
               end else if (stop) begin
                  state_in = S_FINAL;
               end else begin
                  idx_in   = '0;
                  found_in = 1'b0;
                  state_in = S_ROUND;
               end
            end else if (have_pend_ff) begin
               state_in = S_FINAL;
            end else begin
               ret_in   = S_IDLE;
               state_in = S_PUSH;
               if (item_ff.allow_defer) begin
                  res_in = make_result(DEC_DEFER, cause_ff, cfg.retry_delay_ms, 1'b0, '0,
                                       1'b1, models_now);
               end else begin
                  res_in = make_result(DEC_DENY, cause_ff, '0, 1'b0, '0, 1'b1, models_now);
               end
            end
         end
         S_FINAL: begin
            res_in   = make_result(DEC_EVICT, cause_ff, '0, 1'b1, pend_id_ff, 1'b1,
                                   models_now);
            ret_in   = S_IDLE;
            state_in = S_PUSH;
         end
         S_PUSH: begin
            if (push_go) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ret_ff;
               idx_in       = '0;
               found_in     = 1'b0;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         admit_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         admit_ff     <= admit_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      op_ff        <= op_in;
      idx_ff       <= idx_in;
      match_idx_ff <= match_idx_in;
      free_idx_ff  <= free_idx_in;
      best_idx_ff  <= best_idx_in;
      match_ff     <= match_in;
      free_ff      <= free_in;
      found_ff     <= found_in;
      ram_sum_ff   <= ram_sum_in;
      vram_sum_ff  <= vram_sum_in;
      best_age_ff  <= best_age_in;
      cause_ff     <= cause_in;
      bygpu_ff     <= bygpu_in;
      have_pend_ff <= have_pend_in;
      need_ff      <= need_in;
      best_amt_ff  <= best_amt_in;
      taken_ff     <= taken_in;
      nvic_ff      <= nvic_in;
      recl_ff      <= recl_in;
      pend_id_ff   <= pend_id_in;
      best_id_ff   <= best_id_in;
      best_prio_ff <= best_prio_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

endmodule
